>>> rtl/alm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants of the block level meter.
// ----------------------------------------------------------------------------
package alm_pkg;

   localparam int DEF_MAX_FRAMES   = 4096;
   localparam int DEF_MAX_CHANNELS = 8;
   localparam int EMA_GAIN         = 9830;
   localparam int MAX_RATE         = 192000;

   localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
   localparam logic [17:0] RST_RATE_HZ       = 18'd44100;
   localparam logic [15:0] RST_LOW_COEFF     = 16'd2780;
   localparam logic [15:0] RST_MID_COEFF     = 16'd23880;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 18;
   localparam int RSP_DATA_W  = 136;

   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_HZ       = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_COEFF     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MID_COEFF     = 8'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT,
      ST_UPD,
      ST_SQ,
      ST_ACC,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_SQRT_START,
      ST_SQRT_RUN,
      ST_STORE,
      ST_FINISH
   } alm_state_type;

   typedef enum logic [2:0] {
      OP_AMP,
      OP_RMS,
      OP_LOW,
      OP_MID,
      OP_HIGH,
      OP_FREQ
   } alm_op_type;

   typedef struct packed {
      logic       latch;
      logic       filt;
      logic       upd;
      logic       sq;
      logic       acc;
      logic       div_start;
      logic       sqrt_start;
      logic       store;
      logic       finish;
      alm_op_type op;
   } alm_cmd_type;

   typedef struct packed {
      logic block_end;
      logic div_done;
      logic sqrt_done;
      logic out_busy;
   } alm_stat_type;

endpackage

>>> rtl/audio_block_level_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_block_level_meter
// Block level meter: amplitude, smoothed amplitude, peak, RMS, three band levels, crossing rate.
// ----------------------------------------------------------------------------
// A sample is accepted only in the idle state: after the accepting edge the filter
// multiply, update, band square and accumulate steps run in turn before the next
// sample is taken. For a block end sample rsp_tvalid rises after 6 divisions, 4 of
// them followed by a square root, with NW = clog2(MAX_FRAMES+1)+34 (47); an unaccepted
// earlier result delays this.
// Synchronous reset restores register defaults and clears all accumulators.
module audio_block_level_meter #(
   parameter int MAX_FRAMES   = alm_pkg::DEF_MAX_FRAMES,
   parameter int MAX_CHANNELS = alm_pkg::DEF_MAX_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // sample_value
   input  logic                            req_tlast,  // block_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // mean_amplitude, peak_level, rms_level, smoothed_amplitude, low_band_rms,
   // mid_band_rms, high_band_rms, crossing_freq_hz, zero fill
   output logic [alm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [alm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [alm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import alm_pkg::*;

   alm_cmd_type  cmd;
   alm_stat_type stat;

   assign csr_ready = 1'b1;

   alm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   alm_datapath #(
      .MAX_FRAMES  (MAX_FRAMES),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .sample_value(req_tdata),
      .block_end   (req_tlast),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> rtl/alm_divsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_divsqrt
// Shared restoring divider and square root, one bit or one digit per cycle.
// ----------------------------------------------------------------------------
module alm_divsqrt #(
   parameter int NW = 47,
   parameter int DW = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  div_start,
   input  logic [NW-1:0]         num,
   input  logic [DW-1:0]         den,
   input  logic                  sqrt_start,
   output logic [NW-1:0]         quot,
   output logic [(NW+1)/2:0]     root_rnd,
   output logic                  div_done,
   output logic                  sqrt_done
);
   localparam int SQ  = (NW + 1) / 2;
   localparam int DCW = $clog2(NW);
   localparam int SCW = $clog2(SQ);

   logic [NW-1:0]  q_ff;
   logic [DW-1:0]  d_ff;
   logic [DW-1:0]  rem_ff;
   logic           dzero_ff;
   logic           dbusy_ff;
   logic [DCW-1:0] dcnt_ff;
   logic           ddone_ff;
   logic [DW:0]    rem_sh;
   logic           qbit;

   logic [2*SQ-1:0] op_ff;
   logic [SQ-1:0]   root_ff;
   logic [SQ+1:0]   srem_ff;
   logic            sbusy_ff;
   logic [SCW-1:0]  scnt_ff;
   logic            sdone_ff;
   logic [SQ+1:0]   srem_sh;
   logic [SQ+1:0]   trial;
   logic            sbit;

   assign quot = dzero_ff ? '0 : q_ff;

   always_comb begin
      rem_sh = {rem_ff, q_ff[NW-1]};
      qbit   = rem_sh >= {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         ddone_ff <= dbusy_ff && (dcnt_ff == DCW'(NW - 1));
         if (div_start) begin
            dbusy_ff <= 1'b1;
            dcnt_ff  <= '0;
         end else if (dbusy_ff) begin
            dcnt_ff <= dcnt_ff + 1'b1;
            if (dcnt_ff == DCW'(NW - 1)) begin
               dbusy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         q_ff     <= num;
         d_ff     <= den;
         rem_ff   <= '0;
         dzero_ff <= den == '0;
      end else if (dbusy_ff) begin
         q_ff   <= {q_ff[NW-2:0], qbit};
         rem_ff <= qbit ? DW'(rem_sh - {1'b0, d_ff}) : DW'(rem_sh);
      end
   end

   always_comb begin
      srem_sh = {srem_ff[SQ-1:0], op_ff[2*SQ-1:2*SQ-2]};
      trial   = {root_ff, 2'b01};
      sbit    = srem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
         sdone_ff <= 1'b0;
         scnt_ff  <= '0;
      end else begin
         sdone_ff <= sbusy_ff && (scnt_ff == SCW'(SQ - 1));
         if (sqrt_start) begin
            sbusy_ff <= 1'b1;
            scnt_ff  <= '0;
         end else if (sbusy_ff) begin
            scnt_ff <= scnt_ff + 1'b1;
            if (scnt_ff == SCW'(SQ - 1)) begin
               sbusy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sqrt_start) begin
         op_ff   <= (2*SQ)'(quot);
         root_ff <= '0;
         srem_ff <= '0;
      end else if (sbusy_ff) begin
         op_ff   <= {op_ff[2*SQ-3:0], 2'b00};
         root_ff <= {root_ff[SQ-2:0], sbit};
         srem_ff <= sbit ? (srem_sh - trial) : srem_sh;
      end
   end

   assign root_rnd  = {1'b0, root_ff} + (SQ+1)'(srem_ff > (SQ+2)'(root_ff));
   assign div_done  = ddone_ff;
   assign sqrt_done = sdone_ff;

endmodule

>>> rtl/alm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_datapath
// Configuration, per-sample accumulators, band filters and result registers.
// ----------------------------------------------------------------------------
module alm_datapath #(
   parameter int MAX_FRAMES   = 4096,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  alm_pkg::alm_cmd_type               cmd,
   output alm_pkg::alm_stat_type              stat,
   input  logic [15:0]                        sample_value,
   input  logic                               block_end,
   input  logic                               csr_valid,
   input  logic [alm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [alm_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [alm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import alm_pkg::*;

   localparam int FW = $clog2(MAX_FRAMES + 1);
   localparam int SW = $clog2(MAX_FRAMES * MAX_CHANNELS + 1);
   localparam int CW = $clog2(MAX_CHANNELS + 1);
   localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int AW = SW + 16;
   localparam int QW = FW + 31;
   localparam int EW = FW + 33;
   localparam int NW = EW + 1;
   localparam int DW = SW + 1;
   localparam int SQ = (NW + 1) / 2;

   logic [3:0]  chan_cnt_ff;
   logic [17:0] rate_ff;
   logic [15:0] lcoef_ff;
   logic [15:0] mcoef_ff;

   logic [CW-1:0] chans_eff;
   logic [17:0]   rate_eff;

   logic signed [15:0] x_ff;
   logic               end_ff;
   logic [15:0]        mag_ff;
   logic               take_ff;
   logic               ch0_ff;
   logic signed [49:0] lprod_ff;
   logic signed [49:0] mprod_ff;
   logic [33:0]        sq_lo_ff;
   logic [33:0]        sq_mb_ff;
   logic [33:0]        sq_hb_ff;
   logic [30:0]        sq_mag_ff;

   logic [IW-1:0]      ci_ff;
   logic [FW-1:0]      fc_ff;
   logic [SW-1:0]      sc_ff;
   logic [AW-1:0]      abs_ff;
   logic [15:0]        peak_ff;
   logic [QW-1:0]      sqsum_ff;
   logic [EW-1:0]      le_ff;
   logic [EW-1:0]      me_ff;
   logic [EW-1:0]      he_ff;
   logic [FW-1:0]      cc_ff;
   logic               prevneg_ff;
   logic               havprev_ff;
   logic signed [31:0] lf_ff;
   logic signed [31:0] mf_ff;
   logic [15:0]        smooth_ff;

   logic [FW+17:0]     fprod_ff;
   logic signed [32:0] smprod_ff;
   logic [15:0]        res_amp_ff;
   logic [15:0]        res_rms_ff;
   logic [15:0]        res_low_ff;
   logic [15:0]        res_mid_ff;
   logic [15:0]        res_high_ff;
   logic [16:0]        res_freq_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [15:0] x_in;
   logic [15:0]        mag_in;
   logic [FW+CW-1:0]   frame_prod;
   logic               take_in;
   logic signed [32:0] x31;
   logic signed [32:0] dl;
   logic signed [32:0] dm;
   logic signed [16:0] lo_w;
   logic signed [16:0] md_w;
   logic signed [17:0] mb_w;
   logic signed [17:0] hb_w;
   logic signed [33:0] lo_sq;
   logic signed [35:0] mb_sq;
   logic signed [35:0] hb_sq;
   logic [CW:0]        ci_next;
   logic [NW-1:0]      num_sel;
   logic [DW-1:0]      den_sel;
   logic [NW-1:0]      num_rnd;
   logic [NW-1:0]      quot;
   logic [SQ:0]        root_rnd;
   logic               div_done;
   logic               sqrt_done;
   logic [15:0]        amp_w;
   logic [15:0]        band_w;
   logic signed [33:0] sm_w;
   logic [15:0]        sm_clamp;

   always_comb begin
      if (chan_cnt_ff == 4'd0) begin
         chans_eff = CW'(1);
      end else if (32'(chan_cnt_ff) > MAX_CHANNELS) begin
         chans_eff = CW'(MAX_CHANNELS);
      end else begin
         chans_eff = CW'(chan_cnt_ff);
      end
      if (rate_ff == 18'd0) begin
         rate_eff = 18'd1;
      end else if (32'(rate_ff) > MAX_RATE) begin
         rate_eff = 18'(MAX_RATE);
      end else begin
         rate_eff = rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff <= RST_CHANNEL_COUNT;
         rate_ff     <= RST_RATE_HZ;
         lcoef_ff    <= RST_LOW_COEFF;
         mcoef_ff    <= RST_MID_COEFF;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: chan_cnt_ff <= csr_data[3:0];
            REG_RATE_HZ:       rate_ff     <= csr_data;
            REG_LOW_COEFF:     lcoef_ff    <= csr_data[15:0];
            REG_MID_COEFF:     mcoef_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      x_in       = $signed(sample_value);
      mag_in     = x_in[15] ? 16'(-x_in) : x_in;
      frame_prod = (FW+CW)'(fc_ff * chans_eff);
      if (ci_ff == '0) begin
         take_in = fc_ff < FW'(MAX_FRAMES);
      end else begin
         take_in = sc_ff < frame_prod;
      end
      x31   = {x_ff[15], x_ff, 16'd0};
      dl    = x31 - {lf_ff[31], lf_ff};
      dm    = x31 - {mf_ff[31], mf_ff};
      lo_w  = 17'(($signed({lf_ff[31], lf_ff}) + 33'sd32768) >>> 16);
      md_w  = 17'(($signed({mf_ff[31], mf_ff}) + 33'sd32768) >>> 16);
      mb_w  = 18'(md_w) - 18'(lo_w);
      hb_w  = 18'(x_ff) - 18'(md_w);
      lo_sq = lo_w * lo_w;
      mb_sq = mb_w * mb_w;
      hb_sq = hb_w * hb_w;
      ci_next = (CW+1)'(ci_ff) + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x_ff   <= x_in;
         mag_ff <= mag_in;
         end_ff <= block_end;
      end
      if (cmd.filt) begin
         take_ff  <= take_in;
         ch0_ff   <= ci_ff == '0;
         lprod_ff <= $signed({1'b0, lcoef_ff}) * dl;
         mprod_ff <= $signed({1'b0, mcoef_ff}) * dm;
      end
      if (cmd.sq) begin
         sq_lo_ff  <= 34'(lo_sq);
         sq_mb_ff  <= 34'(mb_sq);
         sq_hb_ff  <= 34'(hb_sq);
         sq_mag_ff <= 31'(mag_ff * mag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff      <= '0;
         fc_ff      <= '0;
         sc_ff      <= '0;
         abs_ff     <= '0;
         peak_ff    <= '0;
         sqsum_ff   <= '0;
         le_ff      <= '0;
         me_ff      <= '0;
         he_ff      <= '0;
         cc_ff      <= '0;
         prevneg_ff <= 1'b0;
         havprev_ff <= 1'b0;
         lf_ff      <= '0;
         mf_ff      <= '0;
         smooth_ff  <= '0;
      end else begin
         if (cmd.upd) begin
            ci_ff <= (ci_next >= (CW+1)'(chans_eff)) ? '0 : IW'(ci_next);
            if (take_ff) begin
               sc_ff  <= sc_ff + 1'b1;
               abs_ff <= abs_ff + AW'(mag_ff);
               if (ch0_ff) begin
                  fc_ff <= fc_ff + 1'b1;
                  if (mag_ff > peak_ff) begin
                     peak_ff <= mag_ff;
                  end
                  if (havprev_ff && (x_ff[15] != prevneg_ff)) begin
                     cc_ff <= cc_ff + 1'b1;
                  end
                  prevneg_ff <= x_ff[15];
                  havprev_ff <= 1'b1;
                  lf_ff <= lf_ff + 32'((lprod_ff + 50'sd32768) >>> 16);
                  mf_ff <= mf_ff + 32'((mprod_ff + 50'sd32768) >>> 16);
               end
            end
         end
         if (cmd.acc && take_ff && ch0_ff) begin
            sqsum_ff <= sqsum_ff + QW'(sq_mag_ff);
            le_ff    <= le_ff + EW'(sq_lo_ff);
            me_ff    <= me_ff + EW'(sq_mb_ff);
            he_ff    <= he_ff + EW'(sq_hb_ff);
         end
         if (cmd.finish) begin
            ci_ff      <= '0;
            fc_ff      <= '0;
            sc_ff      <= '0;
            abs_ff     <= '0;
            peak_ff    <= '0;
            sqsum_ff   <= '0;
            le_ff      <= '0;
            me_ff      <= '0;
            he_ff      <= '0;
            cc_ff      <= '0;
            prevneg_ff <= 1'b0;
            havprev_ff <= 1'b0;
            smooth_ff  <= sm_clamp;
         end
      end
   end

   always_comb begin
      unique case (cmd.op)
         OP_AMP: begin
            num_sel = NW'(abs_ff);
            den_sel = DW'(sc_ff);
         end
         OP_RMS: begin
            num_sel = NW'(sqsum_ff);
            den_sel = DW'(fc_ff);
         end
         OP_LOW: begin
            num_sel = NW'(le_ff);
            den_sel = DW'(fc_ff);
         end
         OP_MID: begin
            num_sel = NW'(me_ff);
            den_sel = DW'(fc_ff);
         end
         OP_HIGH: begin
            num_sel = NW'(he_ff);
            den_sel = DW'(fc_ff);
         end
         OP_FREQ: begin
            num_sel = NW'(fprod_ff);
            den_sel = DW'({fc_ff, 1'b0});
         end
         default: begin
            num_sel = '0;
            den_sel = '0;
         end
      endcase
      num_rnd = num_sel + NW'(den_sel >> 1);
   end

   alm_divsqrt #(
      .NW(NW),
      .DW(DW)
   ) u_divsqrt (
      .clock     (clock),
      .reset     (reset),
      .div_start (cmd.div_start),
      .num       (num_rnd),
      .den       (den_sel),
      .sqrt_start(cmd.sqrt_start),
      .quot      (quot),
      .root_rnd  (root_rnd),
      .div_done  (div_done),
      .sqrt_done (sqrt_done)
   );

   always_comb begin
      amp_w    = (quot > NW'(32768)) ? 16'd32768 : quot[15:0];
      band_w   = (root_rnd > (SQ+1)'(65535)) ? 16'hFFFF : root_rnd[15:0];
      sm_w     = 34'(smooth_ff) + 34'((smprod_ff + 33'sd32768) >>> 16);
      if (sm_w < 0) begin
         sm_clamp = 16'd0;
      end else if (sm_w > 34'sd32768) begin
         sm_clamp = 16'd32768;
      end else begin
         sm_clamp = sm_w[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         fprod_ff <= cc_ff * rate_eff;
      end
      if (cmd.store) begin
         unique case (cmd.op)
            OP_AMP: begin
               res_amp_ff <= amp_w;
               smprod_ff  <= 33'(EMA_GAIN) * ($signed({1'b0, amp_w})
                             - $signed({1'b0, smooth_ff}));
            end
            OP_RMS:  res_rms_ff  <= root_rnd[15:0];
            OP_LOW:  res_low_ff  <= band_w;
            OP_MID:  res_mid_ff  <= band_w;
            OP_HIGH: res_high_ff <= band_w;
            OP_FREQ: res_freq_ff <= quot[16:0];
            default: ;
         endcase
      end
      if (cmd.finish) begin
         rsp_data_ff <= {7'd0, res_freq_ff, res_high_ff, res_mid_ff, res_low_ff,
                         sm_clamp, res_rms_ff, peak_ff, res_amp_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data_ff;
   assign stat.block_end = end_ff;
   assign stat.div_done  = div_done;
   assign stat.sqrt_done = sqrt_done;
   assign stat.out_busy  = rsp_valid_ff && !rsp_tready;

endmodule

>>> rtl/alm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_ctrl
// Sequencer for per-sample steps and the end-of-block result pass.
// ----------------------------------------------------------------------------
module alm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  alm_pkg::alm_stat_type stat,
   output alm_pkg::alm_cmd_type  cmd
);
   import alm_pkg::*;

   alm_state_type state_ff;
   alm_state_type state_in;
   alm_op_type    op_ff;
   alm_op_type    op_in;
   logic          sqrt_op;

   assign sqrt_op = (op_ff == OP_RMS) || (op_ff == OP_LOW) || (op_ff == OP_MID)
                    || (op_ff == OP_HIGH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_AMP;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_FILT;
         ST_FILT:       state_in = ST_UPD;
         ST_UPD:        state_in = ST_SQ;
         ST_SQ:         state_in = ST_ACC;
         ST_ACC: begin
            op_in    = OP_AMP;
            state_in = stat.block_end ? ST_DIV_START : ST_IDLE;
         end
         ST_DIV_START:  state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (stat.div_done) state_in = sqrt_op ? ST_SQRT_START : ST_STORE;
         end
         ST_SQRT_START: state_in = ST_SQRT_RUN;
         ST_SQRT_RUN:   if (stat.sqrt_done) state_in = ST_STORE;
         ST_STORE: begin
            state_in = ST_DIV_START;
            unique case (op_ff)
               OP_AMP:  op_in = OP_RMS;
               OP_RMS:  op_in = OP_LOW;
               OP_LOW:  op_in = OP_MID;
               OP_MID:  op_in = OP_HIGH;
               OP_HIGH: op_in = OP_FREQ;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_FINISH:     if (!stat.out_busy) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.op         = op_ff;
      req_tready     = state_ff == ST_IDLE;
      cmd.latch      = (state_ff == ST_IDLE) && req_tvalid;
      cmd.filt       = state_ff == ST_FILT;
      cmd.upd        = state_ff == ST_UPD;
      cmd.sq         = state_ff == ST_SQ;
      cmd.acc        = state_ff == ST_ACC;
      cmd.div_start  = state_ff == ST_DIV_START;
      cmd.sqrt_start = state_ff == ST_SQRT_START;
      cmd.store      = state_ff == ST_STORE;
      cmd.finish     = (state_ff == ST_FINISH) && !stat.out_busy;
   end

endmodule

>>> rtl/alm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_checker
// Port-level checks of the block level meter.
// ----------------------------------------------------------------------------
module alm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [alm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import alm_pkg::*;

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_amp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[15:0] <= 16'd32768) && (rsp_tdata[31:16] <= 16'd32768)
                      && (rsp_tdata[63:48] <= 16'd32768)))
      else $error("amplitude out of range");

   a_freq_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[128:112] <= 17'd96000) && (rsp_tdata[135:129] == 7'd0)))
      else $error("crossing frequency out of range");

endmodule

bind audio_block_level_meter alm_checker u_alm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

>>> dv/audio_block_level_meter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_block_level_meter_test
// Self-checking bench for the block level meter. Samples are streamed in
// blocks under several register settings. A bit-accurate level predictor
// computes every block result, and the results are compared in order, field
// by field, with random stalls on both streams.
// ----------------------------------------------------------------------------
module audio_block_level_meter_test;
   import alm_pkg::*;

   localparam int FRAME_LIMIT = DEF_MAX_FRAMES;
   localparam int CHAN_LIMIT  = DEF_MAX_CHANNELS;

   typedef struct packed {
      logic [16:0] freq;
      logic [15:0] high;
      logic [15:0] mid;
      logic [15:0] low;
      logic [15:0] smooth;
      logic [15:0] rms;
      logic [15:0] peak;
      logic [15:0] amp;
   } levels_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   audio_block_level_meter dut (.*);

   always #2 clock = ~clock;

   levels_type pending_levels[$];
   int         error_count = 0;
   bit         quiet = 1'b0;

   // Predictor state.
   logic [3:0]  cfg_chans;
   logic [17:0] cfg_rate;
   logic [15:0] cfg_low_coeff, cfg_mid_coeff;
   int unsigned chan_idx, frames, samples, crossings, peak, smooth;
   longint unsigned abs_acc, sq_acc, low_acc, mid_acc, high_acc;
   longint low_filt, mid_filt;
   bit prev_neg, have_prev;

   function automatic longint rnd_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint unsigned rnd_div(longint unsigned n, longint unsigned d);
      if (d == 0) return 0;
      return (n + d / 2) / d;
   endfunction

   function automatic longint unsigned rnd_sqrt(longint unsigned n);
      longint unsigned r, b, m;
      r = 0;
      b = 64'd1 << 62;
      m = n;
      while (b > m) b >>= 2;
      while (b != 0) begin
         if (m >= r + b) begin
            m -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (n - r * r > r) r++;
      return r;
   endfunction

   function automatic logic [15:0] band_rms(longint unsigned energy, int unsigned nf);
      longint unsigned v;
      v = rnd_sqrt(rnd_div(energy, nf));
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic clear_block();
      chan_idx = 0; frames = 0; samples = 0; crossings = 0; peak = 0;
      abs_acc = 0; sq_acc = 0; low_acc = 0; mid_acc = 0; high_acc = 0;
      prev_neg = 0; have_prev = 0;
   endtask

   task automatic meter_step(logic signed [15:0] s, logic last);
      int unsigned     chans, mag, rate;
      bit              take, neg;
      longint          x31, lo, md, mb, hb, sm;
      longint unsigned amp;
      levels_type      lv;
      chans = (cfg_chans == 0) ? 1 : (cfg_chans > CHAN_LIMIT ? CHAN_LIMIT : cfg_chans);
      mag = (s < 0) ? -int'(s) : int'(s);
      if (chan_idx == 0) take = frames < FRAME_LIMIT;
      else take = longint'(samples) < longint'(frames) * chans;
      if (take) begin
         samples++;
         abs_acc += mag;
         if (chan_idx == 0) begin
            neg = s < 0;
            frames++;
            if (mag > peak) peak = mag;
            sq_acc += longint'(mag) * mag;
            if (have_prev && neg != prev_neg) crossings++;
            prev_neg = neg;
            have_prev = 1;
            x31 = longint'(s) * 65536;
            low_filt += rnd_shift(longint'(cfg_low_coeff) * (x31 - low_filt), 16);
            mid_filt += rnd_shift(longint'(cfg_mid_coeff) * (x31 - mid_filt), 16);
            lo = rnd_shift(low_filt, 16);
            md = rnd_shift(mid_filt, 16);
            mb = md - lo;
            hb = longint'(s) - md;
            low_acc += lo * lo;
            mid_acc += mb * mb;
            high_acc += hb * hb;
         end
      end
      chan_idx = (chan_idx + 1 >= chans) ? 0 : chan_idx + 1;
      if (!last) return;
      amp = rnd_div(abs_acc, samples);
      if (amp > 32768) amp = 32768;
      rate = (cfg_rate == 0) ? 1 : (cfg_rate > MAX_RATE ? MAX_RATE : cfg_rate);
      sm = smooth;
      sm += rnd_shift(longint'(EMA_GAIN) * (longint'(amp) - sm), 16);
      if (sm < 0) sm = 0;
      if (sm > 32768) sm = 32768;
      smooth = 32'(sm);
      lv.amp = amp[15:0];
      lv.peak = peak[15:0];
      lv.rms = 16'(rnd_sqrt(rnd_div(sq_acc, frames)));
      lv.smooth = smooth[15:0];
      lv.low = band_rms(low_acc, frames);
      lv.mid = band_rms(mid_acc, frames);
      lv.high = band_rms(high_acc, frames);
      lv.freq = 17'(rnd_div(longint'(crossings) * rate, 2 * longint'(frames)));
      pending_levels.push_back(lv);
      clear_block();
   endtask

   // Result checker.
   always @(posedge clock) begin
      levels_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(levels_type)-1:0];
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
         end else begin
            want = pending_levels.pop_front();
            if (got.amp !== want.amp)
               $display("%0t: amplitude expected %0d actual %0d", $time, want.amp, got.amp);
            if (got.peak !== want.peak)
               $display("%0t: peak expected %0d actual %0d", $time, want.peak, got.peak);
            if (got.rms !== want.rms)
               $display("%0t: rms expected %0d actual %0d", $time, want.rms, got.rms);
            if (got.smooth !== want.smooth)
               $display("%0t: smoothed expected %0d actual %0d", $time, want.smooth,
                        got.smooth);
            if (got.low !== want.low)
               $display("%0t: low band expected %0d actual %0d", $time, want.low, got.low);
            if (got.mid !== want.mid)
               $display("%0t: mid band expected %0d actual %0d", $time, want.mid, got.mid);
            if (got.high !== want.high)
               $display("%0t: high band expected %0d actual %0d", $time, want.high, got.high);
            if (got.freq !== want.freq)
               $display("%0t: frequency expected %0d actual %0d", $time, want.freq, got.freq);
            if (rsp_tdata[RSP_DATA_W-1:$bits(levels_type)] !== '0)
               $display("%0t: fill bits expected 0 actual %h", $time,
                        rsp_tdata[RSP_DATA_W-1:$bits(levels_type)]);
            if (got !== want || rsp_tdata[RSP_DATA_W-1:$bits(levels_type)] !== '0)
               error_count++;
         end
      end
   end

   // Result back-pressure.
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(logic [15:0] value, logic last);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      meter_step(value, last);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_CHANNEL_COUNT: cfg_chans = value[3:0];
         REG_RATE_HZ:       cfg_rate = value[17:0];
         REG_LOW_COEFF:     cfg_low_coeff = value[15:0];
         REG_MID_COEFF:     cfg_mid_coeff = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(int chans, int rate, int lowc, int midc);
      csr_write(REG_CHANNEL_COUNT, CSR_DATA_W'(chans));
      csr_write(REG_RATE_HZ, CSR_DATA_W'(rate));
      csr_write(REG_LOW_COEFF, CSR_DATA_W'(lowc));
      csr_write(REG_MID_COEFF, CSR_DATA_W'(midc));
   endtask

   function automatic logic [15:0] random_sample(int style);
      case (style)
         0: return 16'($urandom());
         1: return 16'($urandom_range(0, 255) - 128);
         2: return ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
         default: return 16'($urandom_range(0, 8191) - 4096);
      endcase
   endfunction

   task automatic test_extremes();
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h8000, 1'b1);
      drain();
   endtask

   task automatic test_partial_frame();
      set_regs(3, 48000, 65535, 0);
      send_sample(16'h1234, 1'b0);
      send_sample(16'hF000, 1'b0);
      send_sample(16'h0100, 1'b0);
      send_sample(16'hEDCC, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      drain();
   endtask

   task automatic test_register_edges();
      set_regs(0, 0, 0, 65535);
      for (int i = 0; i < 6; i++) send_sample((i % 2) ? 16'hC000 : 16'h4000, i == 5);
      drain();
      set_regs(15, 262143, 1, 65534);
      for (int i = 0; i < 10; i++) send_sample(random_sample(0), i == 9);
      drain();
   endtask

   task automatic test_random();
      int sent, len, style;
      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) set_regs(2, 44100, 2780, 23880);
         else set_regs($urandom_range(0, 15), $urandom_range(0, 262143),
                       $urandom(), $urandom());
         if (phase == 5) quiet = 1'b1;
         while (sent < (phase + 1) * 280) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 24);
            style = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) send_sample(random_sample(style), i == len - 1);
            sent += len;
         end
         drain();
      end
   endtask

   initial begin
      cfg_chans = RST_CHANNEL_COUNT;
      cfg_rate = RST_RATE_HZ;
      cfg_low_coeff = RST_LOW_COEFF;
      cfg_mid_coeff = RST_MID_COEFF;
      low_filt = 0;
      mid_filt = 0;
      smooth = 0;
      clear_block();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_partial_frame();
      test_register_edges();
      test_random();
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
